[sv/sha512_pkg.sv]
package sha512_pkg;

    localparam int MAX_BYTES = 111;

    typedef struct packed {
        logic        too_long;
        logic [6:0]  byte_count;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } core_state_t;

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] k;
        case (i)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] start_h(input logic [2:0] i);
        logic [63:0] h;
        case (i)
            3'd0: h = 64'h6a09e667f3bcc908;
            3'd1: h = 64'hbb67ae8584caa73b;
            3'd2: h = 64'h3c6ef372fe94f82b;
            3'd3: h = 64'ha54ff53a5f1d36f1;
            3'd4: h = 64'h510e527fade682d1;
            3'd5: h = 64'h9b05688c2b3e6c1f;
            3'd6: h = 64'h1f83d9abfb41bd6b;
            3'd7: h = 64'h5be0cd19137e2179;
            default: h = 64'h0;
        endcase
        return h;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

[sv/sha512_front.sv]
module sha512_front import sha512_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          carries_byte,
    input  logic [7:0]    data_byte,
    input  logic          end_of_message,
    output logic          job_valid,
    input  logic          job_ready,
    output job_t          job,
    output logic [1023:0] job_block
);

    logic [1023:0] block_reg, block_next;
    logic [6:0]    count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          full_reg, full_next;
    job_t          job_reg, job_next;
    logic [1023:0] jblk_reg;
    logic          take;
    logic          ovf_now;
    logic [6:0]    cnt_now;
    logic [1023:0] blk_now;
    logic [1023:0] blk_pad;

    assign in_ready  = !full_reg;
    assign take      = in_valid && in_ready;
    assign job_valid = full_reg;
    assign job       = job_reg;
    assign job_block = jblk_reg;

    always_comb begin
        blk_now = block_reg;
        cnt_now = count_reg;
        ovf_now = ovf_reg;
        if (carries_byte) begin
            if (count_reg < 7'(MAX_BYTES)) begin
                blk_now[1023 - 8 * count_reg -: 8] = data_byte;
                cnt_now = count_reg + 7'd1;
            end else begin
                ovf_now = 1'b1;
            end
        end
        blk_pad = blk_now;
        blk_pad[1023 - 8 * cnt_now -: 8] = 8'h80;
        blk_pad[63:0] = {54'd0, cnt_now, 3'd0};
    end

    always_comb begin
        block_next = block_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        full_next  = full_reg;
        job_next   = job_reg;
        if (full_reg && job_ready) begin
            full_next = 1'b0;
        end
        if (take) begin
            if (end_of_message) begin
                block_next = '0;
                count_next = '0;
                ovf_next   = 1'b0;
                full_next  = 1'b1;
                job_next   = '{too_long: ovf_now, byte_count: cnt_now};
            end else begin
                block_next = blk_now;
                count_next = cnt_now;
                ovf_next   = ovf_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end else begin
            block_reg <= block_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            full_reg  <= full_next;
        end
        job_reg <= job_next;
        if (take && end_of_message) begin
            jblk_reg <= blk_pad;
        end
    end

endmodule

[sv/sha512_core.sv]
module sha512_core import sha512_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    input  logic [1023:0] job_block,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [63:0]   m_word,
    output logic [2:0]    m_num,
    output logic          m_last,
    output logic          m_err
);

    core_state_t   state_reg, state_next;
    logic [6:0]    rnd_reg, rnd_next;
    logic [2:0]    oidx_reg, oidx_next;
    logic          err_reg, err_next;
    logic [63:0]   w_reg [16];
    logic [63:0]   v_reg [8];
    logic [63:0]   wi, s1, ch, t1, s0, mj, sg0, sg1, wnew;
    logic          start, adv;

    assign start = (state_reg == ST_IDLE) && job_valid;
    assign adv   = (state_reg == ST_OUT) && m_ready;

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        oidx_next  = oidx_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    err_next  = job.too_long;
                    rnd_next  = '0;
                    oidx_next = '0;
                    state_next = job.too_long ? ST_OUT : ST_ROUND;
                end
            end
            ST_ROUND: begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (err_reg || oidx_reg == 3'd7) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        job_ready = (state_reg == ST_IDLE);
        m_valid   = (state_reg == ST_OUT);
        m_num     = err_reg ? 3'd0 : oidx_reg;
        m_last    = err_reg || (oidx_reg == 3'd7);
        m_err     = err_reg;
        m_word    = err_reg ? 64'd0 : v_reg[0] + start_h(oidx_reg);
    end

    always_comb begin
        sg0  = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        sg1  = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        wnew = w_reg[0] + sg0 + w_reg[9] + sg1;
        wi   = w_reg[0];
        s1   = rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + s1 + ch + round_k(rnd_reg) + wi;
        s0   = rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39);
        mj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            err_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
            err_reg   <= err_next;
        end
        if (start) begin
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= job_block[1023 - 64 * i -: 64];
            end
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= start_h(3'(i));
            end
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < 14; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[14] <= w_reg[15];
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + s0 + mj;
        end else if (adv) begin
            for (int i = 0; i < 7; i++) begin
                v_reg[i] <= v_reg[i + 1];
            end
            v_reg[7] <= v_reg[0];
        end
    end

endmodule

[sv/sha512_single_block_hash_top.sv]
// Flow: each byte word is taken into the buffer; after the end word the job is
// handed to the core, which runs 80 rounds and then gives eight digest words at
// one per cycle while m_tready is high (an overlong message skips the rounds and
// gives one error word). Throughput: one byte word per cycle while s_tready is
// high; a second message is buffered while the first hashes.
// Reset: synchronous active-low aresetn clears the buffer, counts and control.
module sha512_single_block_hash_top import sha512_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_message
    input  logic        s_tuser,   // carries_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // 5'b0, word_number, digest_word
    output logic        m_tlast,   // last_word
    output logic        m_tuser    // too_long
);

    logic          job_valid, job_ready;
    job_t          job;
    logic [1023:0] job_block;
    logic [63:0]   word;
    logic [2:0]    num;

    sha512_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .carries_byte(s_tuser), .data_byte(s_tdata), .end_of_message(s_tlast),
        .job_valid, .job_ready, .job, .job_block
    );

    sha512_core u_core (
        .aclk, .aresetn,
        .job_valid, .job_ready, .job, .job_block,
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_word(word), .m_num(num), .m_last(m_tlast), .m_err(m_tuser)
    );

    assign m_tdata = {5'd0, num, word};

endmodule
